>>> rtl/lcr_pkg.sv
// ----------------------------------------------------------------------------
// lcr_pkg
// Shared constants and types of the load-cell converter serial reader: the
// register map, the register file layout and the command and status groups
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package lcr_pkg;

   // Default number of data bits per conversion.
   localparam int DATA_BITS_DEFAULT = 24;

   // Widths of the running sum and divider, the result value, the offset and the pulse index.
   localparam int SUM_WIDTH    = 32;
   localparam int VALUE_WIDTH  = 25;
   localparam int OFFSET_WIDTH = 24;
   localparam int PULSE_WIDTH  = 5;

   // Configuration port geometry.
   localparam int CSR_ADDR_WIDTH = 5;
   localparam int CSR_DATA_WIDTH = 32;

   // Register indexes (byte address is four times the index).
   localparam logic [2:0] REG_GAIN_PULSES   = 3'd0;
   localparam logic [2:0] REG_AVERAGE_COUNT = 3'd1;
   localparam logic [2:0] REG_OFFSET        = 3'd2;
   localparam logic [2:0] REG_HALF_PERIOD   = 3'd3;
   localparam logic [2:0] REG_POWER_DOWN    = 3'd4;

   // Current register contents as seen by the datapath.
   typedef struct packed {
      logic [1:0]              gain_pulses;
      logic [7:0]              average_count;
      logic [OFFSET_WIDTH-1:0] offset;
      logic [7:0]              half_period_ticks;
      logic                    power_down;
   } lcr_cfg_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic tick_step;
      logic div_start;
      logic div_step;
      logic load_tick;
      logic load_div;
   } lcr_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic tick_final;
      logic div_last;
   } lcr_status_type;

endpackage

`default_nettype wire

>>> rtl/lcr_ctrl.sv
// ----------------------------------------------------------------------------
// lcr_ctrl
// Sequencing controller: accepts ticks, runs the divider when a tick closes
// an average, and manages the result register and both handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module lcr_ctrl (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  wire                     rsp_stall,
   input  lcr_pkg::lcr_status_type status,
   output lcr_pkg::lcr_cmd_type    cmd
);
   import lcr_pkg::*;

   localparam logic [1:0] ST_RUN  = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_HOLD = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       out_full_ff;
   logic       out_full_in;
   logic       out_free;
   logic       accept;
   logic       taken;

   // The result register can take new data when empty or emptied this cycle.
   assign taken     = out_full_ff && !rsp_stall;
   assign out_free  = !out_full_ff || !rsp_stall;
   assign req_stall = !((state_ff == ST_RUN) && out_free);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = out_full_ff;

   // Next state and commands.
   always_comb begin
      state_in    = state_ff;
      out_full_in = taken ? 1'b0 : out_full_ff;
      cmd         = '0;
      unique case (state_ff)
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               cmd.load_div = 1'b1;
               out_full_in  = 1'b1;
               state_in     = ST_RUN;
            end
         end
         default: begin
            state_in = ST_RUN;
            if (accept) begin
               cmd.tick_step = 1'b1;
               if (status.tick_final) begin
                  cmd.div_start = 1'b1;
                  state_in      = ST_DIV;
               end else begin
                  cmd.load_tick = 1'b1;
                  out_full_in   = 1'b1;
               end
            end
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_RUN;
         out_full_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         out_full_ff <= out_full_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/lcr_dp.sv
// ----------------------------------------------------------------------------
// lcr_dp
// Datapath: serial clock and bit timing, shift register, running sum, a
// one-bit-per-cycle divider for the average, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lcr_dp #(
   parameter int DATA_BITS = lcr_pkg::DATA_BITS_DEFAULT
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  lcr_pkg::lcr_cfg_type                cfg,
   input  lcr_pkg::lcr_cmd_type                cmd,
   output lcr_pkg::lcr_status_type             status,
   input  wire                                 dout_level,
   output logic                                sck_level,
   output logic                                ready_res,
   output logic                                sample_valid,
   output logic signed [lcr_pkg::VALUE_WIDTH-1:0] sample_value
);
   import lcr_pkg::*;

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_HIGH = 2'd1;
   localparam logic [1:0] PH_LOW  = 2'd2;
   localparam int         DIV_STEP_WIDTH = $clog2(SUM_WIDTH);
   localparam logic [DIV_STEP_WIDTH-1:0] DIV_LAST = DIV_STEP_WIDTH'(SUM_WIDTH - 1);

   // Pin timing and accumulation state.
   logic [1:0]             phase_ff, phase_in;
   logic [PULSE_WIDTH-1:0] pulse_index_ff, pulse_index_in;
   logic [7:0]             tick_count_ff, tick_count_in;
   logic [DATA_BITS-1:0]   shift_data_ff, shift_data_in;
   logic [SUM_WIDTH-1:0]   running_sum_ff, running_sum_in;
   logic [7:0]             readings_done_ff, readings_done_in;
   logic                   clock_out_ff, clock_out_in;
   logic                   ready_tick;
   logic                   tick_final;

   // Divider state.
   logic [SUM_WIDTH-1:0]      div_quo_ff;
   logic [7:0]                div_rem_ff;
   logic [7:0]                div_divisor_ff;
   logic                      div_neg_ff;
   logic [DIV_STEP_WIDTH-1:0] div_count_ff;

   // Result register.
   logic                   rsp_sck_ff;
   logic                   rsp_ready_ff;
   logic                   rsp_sample_valid_ff;
   logic [VALUE_WIDTH-1:0] rsp_value_ff;

   // Effective register values: a zero setting acts as one.
   logic [7:0]             half_period;
   logic [1:0]             gain_eff;
   logic [7:0]             count_eff;
   logic [7:0]             tick_inc;
   logic [PULSE_WIDTH-1:0] pulse_inc;
   logic [PULSE_WIDTH:0]   pulse_limit;
   logic [SUM_WIDTH-1:0]   reading_ext;
   logic [SUM_WIDTH-1:0]   sum_add;
   logic [SUM_WIDTH-1:0]   sum_mag;
   logic [7:0]             done_inc;
   logic                   in_data_bits;

   assign half_period  = (cfg.half_period_ticks == 8'd0) ? 8'd1 : cfg.half_period_ticks;
   assign gain_eff     = (cfg.gain_pulses == 2'd0) ? 2'd1 : cfg.gain_pulses;
   assign count_eff    = (cfg.average_count == 8'd0) ? 8'd1 : cfg.average_count;
   assign tick_inc     = tick_count_ff + 8'd1;
   assign pulse_inc    = pulse_index_ff + PULSE_WIDTH'(1);
   assign pulse_limit  = (PULSE_WIDTH + 1)'(DATA_BITS) + (PULSE_WIDTH + 1)'(gain_eff);
   assign in_data_bits = {1'b0, pulse_index_ff} < (PULSE_WIDTH + 1)'(DATA_BITS);
   assign reading_ext  = {{(SUM_WIDTH - DATA_BITS){shift_data_ff[DATA_BITS-1]}},
                          shift_data_ff};
   assign sum_add      = running_sum_ff + reading_ext;
   assign sum_mag      = sum_add[SUM_WIDTH-1] ? (~sum_add + SUM_WIDTH'(1)) : sum_add;
   assign done_inc     = readings_done_ff + 8'd1;

   // Next state of the pin timing for one tick.
   always_comb begin
      phase_in         = phase_ff;
      pulse_index_in   = pulse_index_ff;
      tick_count_in    = tick_count_ff;
      shift_data_in    = shift_data_ff;
      running_sum_in   = running_sum_ff;
      readings_done_in = readings_done_ff;
      clock_out_in     = clock_out_ff;
      ready_tick       = 1'b0;
      tick_final       = 1'b0;
      if (cfg.power_down) begin
         clock_out_in   = 1'b1;
         phase_in       = PH_IDLE;
         pulse_index_in = '0;
         tick_count_in  = '0;
      end else begin
         unique case (phase_ff)
            PH_HIGH: begin
               clock_out_in  = 1'b1;
               tick_count_in = tick_inc;
               if (tick_inc >= half_period) begin
                  if (in_data_bits) begin
                     shift_data_in = {shift_data_ff[DATA_BITS-2:0], dout_level};
                  end
                  tick_count_in = '0;
                  phase_in      = PH_LOW;
               end
            end
            PH_LOW: begin
               clock_out_in  = 1'b0;
               tick_count_in = tick_inc;
               if (tick_inc >= half_period) begin
                  tick_count_in  = '0;
                  pulse_index_in = pulse_inc;
                  if ({1'b0, pulse_inc} >= pulse_limit) begin
                     running_sum_in   = sum_add;
                     readings_done_in = done_inc;
                     pulse_index_in   = '0;
                     phase_in         = PH_IDLE;
                     if (done_inc >= count_eff) begin
                        tick_final       = 1'b1;
                        running_sum_in   = '0;
                        readings_done_in = '0;
                     end
                  end else begin
                     phase_in = PH_HIGH;
                  end
               end
            end
            default: begin
               phase_in       = PH_IDLE;
               clock_out_in   = 1'b0;
               tick_count_in  = '0;
               pulse_index_in = '0;
               if (!dout_level) begin
                  ready_tick = 1'b1;
                  phase_in   = PH_HIGH;
               end
            end
         endcase
      end
   end

   assign status.tick_final = tick_final;
   assign status.div_last   = (div_count_ff == DIV_LAST);

   // Pin timing and accumulation registers, updated once per accepted request.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_IDLE;
         pulse_index_ff   <= '0;
         tick_count_ff    <= '0;
         shift_data_ff    <= '0;
         running_sum_ff   <= '0;
         readings_done_ff <= '0;
         clock_out_ff     <= 1'b0;
      end else if (cmd.tick_step) begin
         phase_ff         <= phase_in;
         pulse_index_ff   <= pulse_index_in;
         tick_count_ff    <= tick_count_in;
         shift_data_ff    <= shift_data_in;
         running_sum_ff   <= running_sum_in;
         readings_done_ff <= readings_done_in;
         clock_out_ff     <= clock_out_in;
      end
   end

   // Restoring divider step: one quotient bit per cycle on the magnitude.
   logic [8:0] rem_shift;
   logic       rem_fits;

   assign rem_shift = {div_rem_ff, div_quo_ff[SUM_WIDTH-1]};
   assign rem_fits  = rem_shift >= {1'b0, div_divisor_ff};

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         div_quo_ff     <= sum_mag;
         div_rem_ff     <= '0;
         div_divisor_ff <= count_eff;
         div_neg_ff     <= sum_add[SUM_WIDTH-1];
         div_count_ff   <= '0;
      end else if (cmd.div_step) begin
         div_rem_ff   <= rem_fits ? 8'(rem_shift - {1'b0, div_divisor_ff}) : rem_shift[7:0];
         div_quo_ff   <= {div_quo_ff[SUM_WIDTH-2:0], rem_fits};
         div_count_ff <= div_count_ff + DIV_STEP_WIDTH'(1);
      end
   end

   // Signed quotient minus the offset, kept to the result width.
   logic [VALUE_WIDTH-1:0] quo_low;
   logic [VALUE_WIDTH-1:0] quo_signed;
   logic [VALUE_WIDTH-1:0] offset_ext;

   assign quo_low    = div_quo_ff[VALUE_WIDTH-1:0];
   assign quo_signed = div_neg_ff ? (~quo_low + VALUE_WIDTH'(1)) : quo_low;
   assign offset_ext = {{(VALUE_WIDTH - OFFSET_WIDTH){cfg.offset[OFFSET_WIDTH-1]}},
                        cfg.offset};

   // Result register.
   always_ff @(posedge clock) begin
      if (cmd.load_tick) begin
         rsp_sck_ff          <= clock_out_in;
         rsp_ready_ff        <= ready_tick;
         rsp_sample_valid_ff <= 1'b0;
         rsp_value_ff        <= '0;
      end else if (cmd.load_div) begin
         rsp_sck_ff          <= clock_out_ff;
         rsp_ready_ff        <= 1'b0;
         rsp_sample_valid_ff <= 1'b1;
         rsp_value_ff        <= quo_signed - offset_ext;
      end
   end

   assign sck_level    = rsp_sck_ff;
   assign ready_res    = rsp_ready_ff;
   assign sample_valid = rsp_sample_valid_ff;
   assign sample_value = $signed(rsp_value_ff);

endmodule

`default_nettype wire

>>> rtl/load_cell_adc_serial_reader_core.sv
// ----------------------------------------------------------------------------
// load_cell_adc_serial_reader_core
// Top level of the serial reader for a 24-bit bridge converter.
// ----------------------------------------------------------------------------
// Each request is one timing tick carrying the sampled data pin, and each
// request yields exactly one response with the serial clock level for that
// tick, the ready flag and, when a tick closes an average, the averaged and
// offset-corrected sample. Ordinary ticks are taken one per clock cycle while
// the response side keeps up. A tick that completes the set number of
// readings stalls further requests until its sample is in the response
// register, because the average is formed by a divider that produces one
// quotient bit per cycle over the 32-bit running sum. Registers are written
// over the APB port and take effect on the next tick.
`default_nettype none

module load_cell_adc_serial_reader_core #(
   parameter int DATA_BITS = lcr_pkg::DATA_BITS_DEFAULT
) (
   input  wire                                       clock,
   input  wire                                       reset,
   // Request channel.
   input  wire                                       req_valid,
   output logic                                      req_stall,
   input  wire                                       req_dout_level,
   // Response channel.
   output logic                                      rsp_valid,
   input  wire                                       rsp_stall,
   output logic                                      rsp_sck_level,
   output logic                                      rsp_ready_res,
   output logic                                      rsp_sample_valid,
   output logic signed [lcr_pkg::VALUE_WIDTH-1:0]    rsp_sample_value,
   // Register port.
   input  wire                                       psel,
   input  wire                                       penable,
   input  wire                                       pwrite,
   input  wire  [lcr_pkg::CSR_ADDR_WIDTH-1:0]        paddr,
   input  wire  [lcr_pkg::CSR_DATA_WIDTH-1:0]        pwdata,
   output logic [lcr_pkg::CSR_DATA_WIDTH-1:0]        prdata,
   output logic                                      pready
);
   import lcr_pkg::*;

   lcr_cfg_type    cfg_ff;
   lcr_cmd_type    cmd;
   lcr_status_type status;
   logic [2:0]     reg_index;
   logic           csr_write;

   assign pready    = 1'b1;
   assign reg_index = paddr[CSR_ADDR_WIDTH-1:2];
   assign csr_write = psel && penable && pwrite && pready;

   // Register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_pulses       <= 2'd1;
         cfg_ff.average_count     <= 8'd1;
         cfg_ff.offset            <= '0;
         cfg_ff.half_period_ticks <= 8'd1;
         cfg_ff.power_down        <= 1'b0;
      end else if (csr_write) begin
         unique case (reg_index)
            REG_GAIN_PULSES:   cfg_ff.gain_pulses       <= pwdata[1:0];
            REG_AVERAGE_COUNT: cfg_ff.average_count     <= pwdata[7:0];
            REG_OFFSET:        cfg_ff.offset            <= pwdata[OFFSET_WIDTH-1:0];
            REG_HALF_PERIOD:   cfg_ff.half_period_ticks <= pwdata[7:0];
            REG_POWER_DOWN:    cfg_ff.power_down        <= pwdata[0];
            default: begin
            end
         endcase
      end
   end

   // Register reads.
   always_comb begin
      unique case (reg_index)
         REG_GAIN_PULSES:   prdata = CSR_DATA_WIDTH'(cfg_ff.gain_pulses);
         REG_AVERAGE_COUNT: prdata = CSR_DATA_WIDTH'(cfg_ff.average_count);
         REG_OFFSET:        prdata = CSR_DATA_WIDTH'(cfg_ff.offset);
         REG_HALF_PERIOD:   prdata = CSR_DATA_WIDTH'(cfg_ff.half_period_ticks);
         REG_POWER_DOWN:    prdata = CSR_DATA_WIDTH'(cfg_ff.power_down);
         default:           prdata = '0;
      endcase
   end

   lcr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   lcr_dp #(
      .DATA_BITS (DATA_BITS)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .cmd          (cmd),
      .status       (status),
      .dout_level   (req_dout_level),
      .sck_level    (rsp_sck_level),
      .ready_res    (rsp_ready_res),
      .sample_valid (rsp_sample_valid),
      .sample_value (rsp_sample_value)
   );

endmodule

`default_nettype wire

>>> rtl/lcr_checker.sv
// ----------------------------------------------------------------------------
// lcr_checker
// Port-level checks of the serial reader, attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module lcr_checker (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire                                    req_valid,
   input  wire                                    req_stall,
   input  wire                                    rsp_valid,
   input  wire                                    rsp_stall,
   input  wire                                    rsp_sck_level,
   input  wire                                    rsp_ready_res,
   input  wire                                    rsp_sample_valid,
   input  wire  [lcr_pkg::VALUE_WIDTH-1:0]        rsp_sample_value
);
   import lcr_pkg::*;

   // A response without a sample carries a zero value.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_sample_valid) |-> (rsp_sample_value == '0))
      else $error("sample value not zero without a sample");

   // Ready is only reported in idle, where the serial clock is low.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready_res) |-> !rsp_sck_level)
      else $error("ready reported with serial clock high");

   // A sample is never reported on the same tick as ready.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_sample_valid) |-> !rsp_ready_res)
      else $error("sample reported together with ready");

   // A stalled response holds its value.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_sample_value)
                                    && $stable(rsp_sample_valid)))
      else $error("stalled response changed");

   // While the response register is held by the receiver, no request is taken.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && rsp_valid && rsp_stall) |-> req_stall)
      else $error("request taken while the response register is held");

endmodule

bind load_cell_adc_serial_reader_core lcr_checker u_lcr_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_sck_level    (rsp_sck_level),
   .rsp_ready_res    (rsp_ready_res),
   .rsp_sample_valid (rsp_sample_valid),
   .rsp_sample_value (rsp_sample_value)
);

`default_nettype wire

>>> tb/lcr_tick_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcr_tick_checker
// Watches the request, response and register channels of the load-cell
// converter reader, works out the response to every accepted tick from its
// own copy of the registers and the pin sequencer state, and compares each
// accepted response against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module lcr_tick_checker #(
   parameter int DATA_BITS = lcr_pkg::DATA_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  logic                                req_dout_level,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic                                rsp_sck_level,
   input  logic                                rsp_ready_res,
   input  logic                                rsp_sample_valid,
   input  logic [lcr_pkg::VALUE_WIDTH-1:0]     rsp_sample_value,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic                                pready,
   input  logic [lcr_pkg::CSR_ADDR_WIDTH-1:0]  paddr,
   input  logic [lcr_pkg::CSR_DATA_WIDTH-1:0]  pwdata,
   output int                                  fail_count,
   output int                                  pending
);
   import lcr_pkg::*;

   typedef struct packed {
      logic                   sck;
      logic                   ready;
      logic                   smp_valid;
      logic [VALUE_WIDTH-1:0] smp_value;
   } pin_result_t;

   typedef enum logic [1:0] {CLK_IDLE, CLK_HIGH, CLK_LOW} sck_phase_e;

   // Register shadow, updated from completed APB writes.
   logic [1:0]              cfg_gain;
   logic [7:0]              cfg_average;
   logic [OFFSET_WIDTH-1:0] cfg_offset;
   logic [7:0]              cfg_half;
   logic                    cfg_pdown;

   // Serial clock sequencer and accumulator state.
   sck_phase_e              rd_phase;
   logic [PULSE_WIDTH-1:0]  pulse_idx;
   logic [7:0]              tick_cnt;
   logic [DATA_BITS-1:0]    shift_reg;
   logic signed [SUM_WIDTH-1:0] sum_acc;
   logic [7:0]              readings_in;
   logic                    sck_q;

   pin_result_t             pin_results_due[$];

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   // Advance the sequencer by one tick and return what the block should answer.
   function automatic pin_result_t advance_pin_tick(input logic dout);
      logic [7:0]  half;
      logic [7:0]  cnt;
      int          gain;
      longint      avg_val;
      pin_result_t res;
      half = (cfg_half == 8'd0) ? 8'd1 : cfg_half;
      cnt  = (cfg_average == 8'd0) ? 8'd1 : cfg_average;
      gain = (cfg_gain == 2'd0) ? 1 : int'(cfg_gain);
      res  = '0;
      if (cfg_pdown) begin
         sck_q     = 1'b1;
         rd_phase  = CLK_IDLE;
         pulse_idx = '0;
         tick_cnt  = '0;
      end else begin
         case (rd_phase)
            CLK_HIGH: begin
               sck_q    = 1'b1;
               tick_cnt = tick_cnt + 8'd1;
               if (tick_cnt >= half) begin
                  // Data is taken on the last tick of the high half.
                  if (pulse_idx < DATA_BITS)
                     shift_reg = {shift_reg[DATA_BITS-2:0], dout};
                  tick_cnt = '0;
                  rd_phase = CLK_LOW;
               end
            end
            CLK_LOW: begin
               sck_q    = 1'b0;
               tick_cnt = tick_cnt + 8'd1;
               if (tick_cnt >= half) begin
                  tick_cnt  = '0;
                  pulse_idx = pulse_idx + 1'b1;
                  if (pulse_idx >= DATA_BITS + gain) begin
                     // Reading complete: accumulate, and report once enough are in.
                     sum_acc = sum_acc +
                        {{(SUM_WIDTH-DATA_BITS){shift_reg[DATA_BITS-1]}}, shift_reg};
                     readings_in = readings_in + 8'd1;
                     pulse_idx   = '0;
                     rd_phase    = CLK_IDLE;
                     if (readings_in >= cnt) begin
                        avg_val = longint'(sum_acc) / longint'(cnt) -
                                  longint'($signed(cfg_offset));
                        res.smp_valid = 1'b1;
                        res.smp_value = avg_val[VALUE_WIDTH-1:0];
                        sum_acc       = '0;
                        readings_in   = '0;
                     end
                  end else begin
                     rd_phase = CLK_HIGH;
                  end
               end
            end
            default: begin
               // Idle: wait for the converter to pull its data pin low.
               rd_phase  = CLK_IDLE;
               sck_q     = 1'b0;
               tick_cnt  = '0;
               pulse_idx = '0;
               if (!dout) begin
                  res.ready = 1'b1;
                  rd_phase  = CLK_HIGH;
               end
            end
         endcase
      end
      res.sck = sck_q;
      return res;
   endfunction

   task automatic flag_mismatch(input string why, input pin_result_t want,
                                input pin_result_t got);
      fail_count = fail_count + 1;
      if (fail_count <= 10)
         $display("%0t: %s: expected sck=%0b ready=%0b valid=%0b value=%0d, got sck=%0b %s",
                  $realtime, why, want.sck, want.ready, want.smp_valid,
                  $signed(want.smp_value), got.sck,
                  $sformatf("ready=%0b valid=%0b value=%0d", got.ready, got.smp_valid,
                            $signed(got.smp_value)));
   endtask

   // Everything is sampled at the rising edge, where the handshakes complete.
   always @(posedge clock) begin
      pin_result_t want;
      pin_result_t got;
      if (reset) begin
         cfg_gain    = 2'd1;
         cfg_average = 8'd1;
         cfg_offset  = '0;
         cfg_half    = 8'd1;
         cfg_pdown   = 1'b0;
         rd_phase    = CLK_IDLE;
         pulse_idx   = '0;
         tick_cnt    = '0;
         shift_reg   = '0;
         sum_acc     = '0;
         readings_in = '0;
         sck_q       = 1'b0;
         pin_results_due.delete();
      end else begin
         // Register writes only happen while nothing is in flight.
         if (psel && penable && pwrite && pready) begin
            case (paddr[CSR_ADDR_WIDTH-1:2])
               REG_GAIN_PULSES:   cfg_gain    = pwdata[1:0];
               REG_AVERAGE_COUNT: cfg_average = pwdata[7:0];
               REG_OFFSET:        cfg_offset  = pwdata[OFFSET_WIDTH-1:0];
               REG_HALF_PERIOD:   cfg_half    = pwdata[7:0];
               REG_POWER_DOWN:    cfg_pdown   = pwdata[0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            pin_results_due.push_back(advance_pin_tick(req_dout_level));
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_sck_level, rsp_ready_res, rsp_sample_valid, rsp_sample_value};
            if (pin_results_due.size() == 0) begin
               flag_mismatch("response with no request outstanding", '0, got);
            end else begin
               want = pin_results_due.pop_front();
               if (got.sck !== want.sck || got.ready !== want.ready ||
                   got.smp_valid !== want.smp_valid || got.smp_value !== want.smp_value)
                  flag_mismatch("response mismatch", want, got);
            end
         end
      end
      pending = pin_results_due.size();
   end

endmodule

>>> tb/load_cell_adc_serial_reader_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// load_cell_adc_serial_reader_core_tb
// Drives pin ticks into the reader as well-formed conversions with random
// data, broken-off readings and power-down spells, under a range of register
// settings and random flow control on both channels, and reports the verdict
// from the checker's failure count.
// ----------------------------------------------------------------------------
module load_cell_adc_serial_reader_core_tb;
   import lcr_pkg::*;

   localparam int DATA_BITS    = DATA_BITS_DEFAULT;
   localparam int RANDOM_TICKS = 1150;
   localparam int CYCLE_LIMIT  = 1_000_000;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_dout_level = 1'b0;
   logic                      rsp_stall = 1'b0;
   logic                      psel = 1'b0;
   logic                      penable = 1'b0;
   logic                      pwrite = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] paddr = '0;
   logic [CSR_DATA_WIDTH-1:0] pwdata = '0;

   logic                      req_stall;
   logic                      rsp_valid;
   logic                      rsp_sck_level;
   logic                      rsp_ready_res;
   logic                      rsp_sample_valid;
   logic [VALUE_WIDTH-1:0]    rsp_sample_value;
   logic [CSR_DATA_WIDTH-1:0] prdata;
   logic                      pready;

   int                        fail_count;
   int                        pending;
   int                        cycle_count = 0;
   int                        cur_gp = 1;
   int                        cur_hp = 1;
   int                        reading_ticks = 0;
   logic                      gaps_on = 1'b1;
   logic                      hold_off_asked = 1'b0;

   load_cell_adc_serial_reader_core i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_dout_level   (req_dout_level),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sck_level    (rsp_sck_level),
      .rsp_ready_res    (rsp_ready_res),
      .rsp_sample_valid (rsp_sample_valid),
      .rsp_sample_value (rsp_sample_value),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   lcr_tick_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_dout_level   (req_dout_level),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sck_level    (rsp_sck_level),
      .rsp_ready_res    (rsp_ready_res),
      .rsp_sample_valid (rsp_sample_valid),
      .rsp_sample_value (rsp_sample_value),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .pready           (pready),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .fail_count       (fail_count),
      .pending          (pending)
   );

   always #10 clock = ~clock;

   // Run limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Response side: random stalls, mostly short, some long, some long free runs,
   // and one long hold-off on request from the stimulus.
   initial begin : response_side
      int stall_left;
      int free_left;
      int r;
      logic hold_off_done;
      stall_left    = 0;
      free_left     = 0;
      hold_off_done = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_asked && !hold_off_done) begin
            hold_off_done = 1'b1;
            stall_left    = 400;
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left = stall_left - 1;
         end else if (free_left > 0) begin
            rsp_stall <= 1'b0;
            free_left = free_left - 1;
         end else begin
            rsp_stall <= 1'b0;
            r = $urandom_range(0, 99);
            free_left  = (r < 10) ? $urandom_range(50, 200) : $urandom_range(0, 6);
            r = $urandom_range(0, 99);
            stall_left = (r < 90) ? $urandom_range(1, 3) : $urandom_range(10, 60);
         end
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (!gaps_on || r < 60)
         return 0;
      if (r < 95)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [DATA_BITS-1:0] pick_word();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10)
         return {1'b1, {(DATA_BITS-1){1'b0}}};
      if (r < 20)
         return {1'b0, {(DATA_BITS-1){1'b1}}};
      if (r < 30)
         return '1;
      if (r < 35)
         return '0;
      return DATA_BITS'($urandom);
   endfunction

   function automatic logic [OFFSET_WIDTH-1:0] pick_offset();
      int r;
      r = $urandom_range(0, 99);
      if (r < 15)
         return {1'b1, {(OFFSET_WIDTH-1){1'b0}}};
      if (r < 30)
         return {1'b0, {(OFFSET_WIDTH-1){1'b1}}};
      if (r < 40)
         return '0;
      return OFFSET_WIDTH'($urandom);
   endfunction

   // One request: optional idle gap, then hold the tick until it is taken.
   // Called and returns at a falling edge, with req_valid left high.
   task automatic send_tick(input logic dout);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_dout_level <= dout;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   // Stop offering requests and wait until every response has come back.
   task automatic drain();
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   // APB write: setup cycle, access cycle, then an idle cycle.
   task automatic csr_write(input logic [2:0] idx, input logic [CSR_DATA_WIDTH-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= data;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   task automatic apply_settings(input logic [1:0] gain, input logic [7:0] avg,
                                 input logic [OFFSET_WIDTH-1:0] ofs,
                                 input logic [7:0] half, input logic pdown);
      csr_write(REG_GAIN_PULSES, CSR_DATA_WIDTH'(gain));
      csr_write(REG_AVERAGE_COUNT, CSR_DATA_WIDTH'(avg));
      csr_write(REG_OFFSET, CSR_DATA_WIDTH'(ofs));
      csr_write(REG_HALF_PERIOD, CSR_DATA_WIDTH'(half));
      csr_write(REG_POWER_DOWN, CSR_DATA_WIDTH'(pdown));
      cur_gp = (gain == 2'd0) ? 1 : int'(gain);
      cur_hp = (half == 8'd0) ? 1 : int'(half);
   endtask

   // One conversion as the pin would show it: ready, then the data bits on the
   // high halves MSB first, then the gain pulses. A non-zero limit cuts the
   // reading short after that many ticks.
   task automatic send_reading(input logic [DATA_BITS-1:0] word, input int limit);
      int sent;
      logic pin;
      sent = 1;
      repeat ($urandom_range(0, 3)) send_tick(1'b1);
      send_tick(1'b0);
      reading_ticks = reading_ticks + 1;
      for (int p = 0; p < DATA_BITS + cur_gp; p++) begin
         for (int h = 0; h < 2 * cur_hp; h++) begin
            if (limit > 0 && sent >= limit)
               return;
            if (h < cur_hp && p < DATA_BITS)
               pin = word[DATA_BITS-1-p];
            else
               pin = 1'($urandom_range(0, 1));
            send_tick(pin);
            sent          = sent + 1;
            reading_ticks = reading_ticks + 1;
         end
      end
   endtask

   initial begin : stimulus
      int phase_no;
      int n_full;
      int cut;
      int r;
      logic [1:0]              gain;
      logic [7:0]              avg;
      logic [OFFSET_WIDTH-1:0] ofs;
      logic [7:0]              half;
      logic                    pdown;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Idle with the pin high, then a reading begun and abandoned by power-down.
      send_tick(1'b1);
      send_tick(1'b1);
      send_tick(1'b0);
      send_tick(1'b1);
      send_tick(1'b0);
      drain();
      csr_write(REG_POWER_DOWN, CSR_DATA_WIDTH'(1));
      send_tick(1'b0);
      send_tick(1'b1);
      send_tick(1'b0);
      drain();

      // Zero in every register where zero behaves as one.
      apply_settings(2'd0, 8'd0, '0, 8'd0, 1'b0);
      for (int i = 0; i < 10; i++)
         send_tick(i[1]);

      // Random phases, each under its own settings, with directed corners first.
      phase_no = 0;
      while (reading_ticks < RANDOM_TICKS) begin
         drain();
         gain = 2'($urandom_range(0, 3));
         r = $urandom_range(0, 99);
         avg = (r < 10) ? 8'd0 : (r < 15) ? 8'($urandom_range(5, 255))
                                          : 8'($urandom_range(1, 4));
         ofs = pick_offset();
         r = $urandom_range(0, 99);
         half = (r < 15) ? 8'd0 : (r < 30) ? 8'($urandom_range(2, 3)) : 8'd1;
         pdown   = ($urandom_range(0, 99) < 8);
         n_full  = $urandom_range(1, 3);
         cut     = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 40) : 0;
         gaps_on = ($urandom_range(0, 3) != 0);
         case (phase_no)
            0: begin
               // Largest count: readings pile up and are reported later.
               gain = 2'd3; avg = 8'd255; half = 8'd1; pdown = 1'b0;
               n_full = 3; cut = 0;
            end
            1: begin
               // Longest half period, broken off part way through a pulse.
               half = 8'd255; pdown = 1'b0; n_full = 0; cut = 300;
            end
            2: begin
               ofs = {1'b1, {(OFFSET_WIDTH-1){1'b0}}}; avg = 8'd2; half = 8'd1;
               pdown = 1'b0;
            end
            3: begin
               ofs = {1'b0, {(OFFSET_WIDTH-1){1'b1}}}; avg = 8'd1; pdown = 1'b0;
            end
            4: begin
               // Back-to-back requests while the response side holds off.
               gain = 2'd1; avg = 8'd1; half = 8'd1; pdown = 1'b0;
               n_full = 5; cut = 0; gaps_on = 1'b0;
               hold_off_asked = 1'b1;
            end
            default: ;
         endcase
         apply_settings(gain, avg, ofs, half, pdown);
         if (pdown) begin
            repeat ($urandom_range(3, 12)) begin
               send_tick(1'($urandom_range(0, 1)));
               reading_ticks = reading_ticks + 1;
            end
         end else begin
            repeat (n_full) send_reading(pick_word(), 0);
            if (cut > 0)
               send_reading(pick_word(), cut);
         end
         phase_no = phase_no + 1;
      end

      drain();
      repeat (40) @(negedge clock);
      if (fail_count == 0 && pending == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
